// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    typedef struct packed {
        logic clear;
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } cdq_cell_ctrl_t;

endpackage

// ===== hw/rtl/cdq_cell.sv =====
// One storage cell of the queue chain: shifts data to or from its neighbors, loads a pushed word or empties.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdq_cell_ctrl_t           ctrl,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic                     left_occ,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic                     right_occ,
    input  logic signed [DATA_W-1:0] right_data,
    output logic                     occ_reg,
    output logic signed [DATA_W-1:0] data_reg,
    output logic                     occ_next,
    output logic signed [DATA_W-1:0] data_next
);

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.add_front)
        begin
            occ_next  = left_occ;
            data_next = left_data;
        end
        else if (ctrl.add_back)
        begin
            if (!occ_reg && left_occ)
            begin
                occ_next  = 1'b1;
                data_next = push_value;
            end
        end
        else if (ctrl.take_front)
        begin
            occ_next  = right_occ;
            data_next = right_data;
        end
        else if (ctrl.take_back)
        begin
            if (occ_reg && !right_occ)
            begin
                occ_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/circular_double_ended_queue.sv =====
// Top level of the double-ended queue: request decode, cell chain and result register.
//
// The block keeps up to capacity signed 32-bit words in a row of cells, cell 0
// holding the front. Requests arrive on the s_ channel: s_tuser carries the
// request kind (push front, push back, pop front, pop back) and s_tdata the
// word to push. Each request transaction yields one result transaction on the
// m_ channel: m_tdata is the front word after the operation (zero when empty),
// m_tuser carries the empty, full and accepted flags. A push onto a full queue
// or a pop from an empty queue changes nothing and reports accepted low.
// The result appears in the cycle after the request is taken, and one request per
// cycle is sustained unless stalled or cfg_valid is high; all cells update at once.
// When the receiver stalls, the result holds in the output register and the
// next request waits until that register is free or being taken.
// The cfg channel writes the capacity (values below 1 act as 1, above 16 as 16)
// and empties the queue; it is always ready and wins over a request.
// After reset the queue is empty with capacity 16 and no result is pending.
module circular_double_ended_queue
    import cdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] front_value
    output logic [2:0]  m_tuser,   // [0] is_empty, [1] is_full, [2] accepted
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // capacity
);

    logic [CAP_W-1:0]         cap_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] front_reg;
    logic                     empty_reg;
    logic                     full_reg;
    logic                     acc_reg;

    logic [DEPTH-1:0]         occ_vec;
    logic [DEPTH-1:0]         occ_nvec;
    logic signed [DATA_W-1:0] data_vec  [DEPTH];
    logic signed [DATA_W-1:0] data_nvec [DEPTH];

    logic [CAP_W-1:0]         cap_wr;
    logic                     in_fire;
    logic                     cfg_fire;
    logic                     is_push;
    logic                     full_now;
    logic                     full_after;
    logic                     req_ok;
    req_t                     req;
    cdq_cell_ctrl_t           ctrl;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (!out_valid_reg || m_tready) && !cfg_valid;
    assign in_fire   = s_tvalid && s_tready;
    assign req       = req_t'(s_tuser);
    assign is_push   = req inside {REQ_PUSH_FRONT, REQ_PUSH_BACK};

    always_comb
    begin
        full_now   = 1'b0;
        full_after = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CAP_W'(i + 1) == cap_reg)
            begin
                full_now   = occ_vec[i];
                full_after = occ_nvec[i];
            end
        end
    end

    assign req_ok = is_push ? !full_now : occ_vec[0];

    always_comb
    begin
        ctrl       = '0;
        ctrl.clear = cfg_fire;
        if (in_fire && req_ok && !cfg_fire)
        begin
            case (req)
                REQ_PUSH_FRONT: ctrl.add_front  = 1'b1;
                REQ_PUSH_BACK:  ctrl.add_back   = 1'b1;
                REQ_POP_FRONT:  ctrl.take_front = 1'b1;
                REQ_POP_BACK:   ctrl.take_back  = 1'b1;
                default:        ctrl            = '0;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                     l_occ;
        logic signed [DATA_W-1:0] l_data;
        logic                     r_occ;
        logic signed [DATA_W-1:0] r_data;

        if (g == 0)
        begin : g_first
            assign l_occ  = 1'b1;
            assign l_data = s_tdata;
        end
        else
        begin : g_mid
            assign l_occ  = occ_vec[g-1];
            assign l_data = data_vec[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign r_occ  = 1'b0;
            assign r_data = '0;
        end
        else
        begin : g_inner
            assign r_occ  = occ_vec[g+1];
            assign r_data = data_vec[g+1];
        end

        cdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .push_value (s_tdata),
            .left_occ   (l_occ),
            .left_data  (l_data),
            .right_occ  (r_occ),
            .right_data (r_data),
            .occ_reg    (occ_vec[g]),
            .data_reg   (data_vec[g]),
            .occ_next   (occ_nvec[g]),
            .data_next  (data_nvec[g])
        );
    end

    always_comb
    begin
        if (cfg_data < CAP_MIN)
        begin
            cap_wr = CAP_MIN;
        end
        else if (cfg_data > CAP_RESET)
        begin
            cap_wr = CAP_RESET;
        end
        else
        begin
            cap_wr = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                cap_reg <= cap_wr;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            front_reg <= occ_nvec[0] ? data_nvec[0] : '0;
            empty_reg <= !occ_nvec[0];
            full_reg  <= full_after;
            acc_reg   <= req_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = front_reg;
    assign m_tuser  = {acc_reg, full_reg, empty_reg};

`ifndef ASSERT_OFF
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & (occ_vec + DEPTH'(1))) == '0)
        else $error("occupied cells are not contiguous from the front");

    a_occ_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) <= int'(cap_reg))
        else $error("more cells occupied than the capacity allows");

    a_full_push_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_push && full_now) |=> !m_tuser[2])
        else $error("push onto a full queue was not rejected");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (occ_vec == '0))
        else $error("capacity write did not empty the queue");
`endif

endmodule
